FILE: design/ple_pkg.sv
// ----------------------------------------------------------------------------
// Positional list engine package
// Shared sizes, action and status codes, the sequencer state type and the memory request.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int Capacity  = 256;
  localparam int DataWidth = 32;
  localparam int SlotW     = $clog2(Capacity);
  localparam int CountW    = $clog2(Capacity + 1);

  typedef enum logic [3:0] {
    ACT_PUSH_HEAD = 4'd0,
    ACT_PUSH_TAIL = 4'd1,
    ACT_POP_HEAD  = 4'd2,
    ACT_POP_TAIL  = 4'd3,
    ACT_READ      = 4'd4,
    ACT_UPDATE    = 4'd5,
    ACT_DELETE    = 4'd6,
    ACT_INSERT    = 4'd7,
    ACT_FIND      = 4'd8,
    ACT_LENGTH    = 4'd9
  } action_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_RANGE    = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT,
    S_FIND,
    S_DONE
  } state_t;

  // Memory request from the sequencer to the entry store.
  typedef struct packed {
    logic                 rd_en;
    logic [SlotW-1:0]     rd_addr;
    logic                 wr_en;
    logic [SlotW-1:0]     wr_addr;
    logic [DataWidth-1:0] wr_data;
  } mem_req_t;

endpackage

FILE: design/ple_store.sv
// ----------------------------------------------------------------------------
// Entry store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module ple_store (
  input  logic                          clk,
  input  ple_pkg::mem_req_t             req,
  output logic [ple_pkg::DataWidth-1:0] rd_data
);
  import ple_pkg::*;

  logic [DataWidth-1:0] mem [Capacity];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

FILE: design/ple_ctrl.sv
// ----------------------------------------------------------------------------
// List sequencer
// Decodes a request, checks it, and walks the store for shifts and finds.
// ----------------------------------------------------------------------------
module ple_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [3:0]                    action,
  input  logic [7:0]                    position,
  input  logic signed [31:0]            value,
  output logic                          busy,
  output logic                          done,
  output logic signed [31:0]            read_value,
  output logic [7:0]                    found_position,
  output logic [8:0]                    list_length,
  output logic [2:0]                    status,
  output ple_pkg::mem_req_t             req,
  input  logic [ple_pkg::DataWidth-1:0] rd_data
);
  import ple_pkg::*;

  state_t state, state_next;

  logic [SlotW-1:0]     head_slot, head_slot_next;
  logic [CountW-1:0]    entry_count, entry_count_next;
  logic [3:0]           act;
  logic [SlotW-1:0]     pos;
  logic [DataWidth-1:0] word;
  logic [CountW-1:0]    idx, idx_next;     // walk position
  logic                 rd_pend, rd_pend_next;
  logic [SlotW-1:0]     wslot, wslot_next; // destination slot for a shift
  logic [DataWidth-1:0] rd_out, rd_out_next;
  logic [SlotW-1:0]     fnd, fnd_next;
  status_t              stat, stat_next;
  logic                 done_next;

  logic [DataWidth-1:0] in_word;
  logic [SlotW-1:0]     in_pos;
  logic [SlotW-1:0]     slot_idx;
  logic                 pos_bad;

  assign in_word  = DataWidth'(value);
  assign in_pos   = SlotW'(position);
  assign pos_bad  = ({1'b0, pos} >= entry_count);
  assign slot_idx = head_slot + idx[SlotW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_slot   <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      head_slot   <= head_slot_next;
      entry_count <= entry_count_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act  <= action;
      pos  <= in_pos;
      word <= in_word;
    end
    idx     <= idx_next;
    rd_pend <= rd_pend_next;
    wslot   <= wslot_next;
    rd_out  <= rd_out_next;
    fnd     <= fnd_next;
    stat    <= stat_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_READ;
      S_READ:  begin
        // Decision state: either finish, or walk the store.
        if (stat_next != ST_OK || done_next) state_next = S_IDLE;
        else if (act == ACT_FIND) state_next = S_FIND;
        else state_next = S_SHIFT;
      end
      S_SHIFT: if (done_next) state_next = S_IDLE;
      S_FIND:  if (done_next) state_next = S_IDLE;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    head_slot_next   = head_slot;
    entry_count_next = entry_count;
    idx_next         = idx;
    rd_pend_next     = 1'b0;
    wslot_next       = wslot;
    rd_out_next      = rd_out;
    fnd_next         = fnd;
    stat_next        = stat;
    done_next        = 1'b0;
    req              = '0;
    case (state)
      S_IDLE: begin
        rd_out_next = '0;
        fnd_next    = '0;
        stat_next   = ST_OK;
      end
      S_READ: begin
        // First cycle after acceptance: check, then act or begin a walk.
        case (act)
          ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
            if (entry_count == CountW'(Capacity)) begin
              stat_next = ST_FULL;
            end else begin
              req.wr_en   = 1'b1;
              req.wr_data = word;
              if (act == ACT_PUSH_HEAD) begin
                head_slot_next = head_slot - 1'b1;
                req.wr_addr    = head_slot - 1'b1;
              end else begin
                req.wr_addr = head_slot + entry_count[SlotW-1:0];
              end
              entry_count_next = entry_count + 1'b1;
            end
            done_next = 1'b1;
          end
          ACT_POP_HEAD, ACT_POP_TAIL, ACT_READ: begin
            if (entry_count == '0) begin
              stat_next = ST_EMPTY;
              done_next = 1'b1;
            end else if (act == ACT_READ && pos_bad) begin
              stat_next = ST_RANGE;
              done_next = 1'b1;
            end else begin
              req.rd_en = 1'b1;
              if (act == ACT_POP_HEAD) begin
                req.rd_addr    = head_slot;
                head_slot_next = head_slot + 1'b1;
                entry_count_next = entry_count - 1'b1;
              end else if (act == ACT_POP_TAIL) begin
                req.rd_addr = head_slot + entry_count[SlotW-1:0] - 1'b1;
                entry_count_next = entry_count - 1'b1;
              end else begin
                req.rd_addr = head_slot + pos;
              end
              idx_next = '0;
            end
          end
          ACT_UPDATE, ACT_DELETE, ACT_INSERT: begin
            if (entry_count == '0) begin
              stat_next = ST_EMPTY;
              done_next = 1'b1;
            end else if (pos_bad) begin
              stat_next = ST_RANGE;
              done_next = 1'b1;
            end else if (act == ACT_UPDATE) begin
              req.wr_en   = 1'b1;
              req.wr_addr = head_slot + pos;
              req.wr_data = word;
              done_next   = 1'b1;
            end else if (act == ACT_DELETE) begin
              entry_count_next = entry_count - 1'b1;
              if (pos == '0) begin
                head_slot_next = head_slot + 1'b1;
                done_next      = 1'b1;
              end else begin
                // Walk upward: slot(i) <- slot(i+1) for i = pos .. count-2.
                idx_next = {1'b0, pos} + 1'b1;
              end
            end else begin
              if (entry_count == CountW'(Capacity)) begin
                stat_next = ST_FULL;
                done_next = 1'b1;
              end else begin
                entry_count_next = entry_count + 1'b1;
                // Walk downward: slot(i) <- slot(i-1) for i = count .. pos+2.
                idx_next = entry_count - 1'b1;
              end
            end
          end
          ACT_FIND: begin
            if (entry_count == '0) begin
              stat_next = ST_EMPTY;
              done_next = 1'b1;
            end else begin
              idx_next = '0;
            end
          end
          default: done_next = 1'b1;
        endcase
      end
      S_SHIFT: begin
        if (act == ACT_POP_HEAD || act == ACT_POP_TAIL || act == ACT_READ) begin
          rd_out_next = rd_data;
          done_next   = 1'b1;
        end else if (act == ACT_DELETE) begin
          // entry_count is already decremented: last source index = count.
          if (rd_pend) begin
            req.wr_en   = 1'b1;
            req.wr_addr = wslot;
            req.wr_data = rd_data;
          end
          if (idx <= entry_count) begin
            req.rd_en    = 1'b1;
            req.rd_addr  = slot_idx;
            rd_pend_next = 1'b1;
            wslot_next   = slot_idx - 1'b1;
            idx_next     = idx + 1'b1;
          end else begin
            done_next = 1'b1;
          end
        end else begin
          // Insert: sources idx from old count-1 down to pos+1.
          if (rd_pend) begin
            req.wr_en   = 1'b1;
            req.wr_addr = wslot;
            req.wr_data = rd_data;
          end
          if (idx > {1'b0, pos}) begin
            req.rd_en    = 1'b1;
            req.rd_addr  = slot_idx;
            rd_pend_next = 1'b1;
            wslot_next   = slot_idx + 1'b1;
            idx_next     = idx - 1'b1;
          end else if (!rd_pend) begin
            req.wr_en   = 1'b1;
            req.wr_addr = head_slot + pos + 1'b1;
            req.wr_data = word;
            done_next   = 1'b1;
          end
        end
      end
      S_FIND: begin
        if (rd_pend && rd_data == word) begin
          fnd_next  = wslot - head_slot;
          done_next = 1'b1;
        end else if (idx < entry_count) begin
          req.rd_en    = 1'b1;
          req.rd_addr  = slot_idx;
          rd_pend_next = 1'b1;
          wslot_next   = slot_idx;
          idx_next     = idx + 1'b1;
        end else begin
          stat_next = ST_NOTFOUND;
          done_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign read_value     = rd_out;
  assign found_position = 8'(fnd);
  assign list_length    = 9'(entry_count);
  assign status         = stat;

endmodule

FILE: design/positional_list_engine.sv
// ----------------------------------------------------------------------------
// Positional list engine
// Bounded circular list of data words held in one synchronous memory.
// ----------------------------------------------------------------------------
// A request is transferred when start is high and busy is low. Pushes,
// update, length, unknown actions, rejected requests and delete at
// position 0 finish in the decision state; pops and read finish when the
// registered read data returns; any other delete and insert-after shift
// the entries past the position through the store, and a find reads entries
// until one matches or the list ends. The single read and write port of the
// entry store moves or compares one entry per cycle. The result appears with
// done for one cycle and cannot be held off by the receiver.
module positional_list_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [3:0]           action,
  input  logic [7:0]           position,
  input  logic signed [31:0]   value,
  output logic                 busy,
  output logic                 done,
  output logic signed [31:0]   read_value,
  output logic [7:0]           found_position,
  output logic [8:0]           list_length,
  output logic [2:0]           status
);
  import ple_pkg::*;

  mem_req_t             req;
  logic [DataWidth-1:0] rd_data;

  ple_ctrl u_ctrl (
    .clk, .rst, .start, .action, .position, .value, .busy, .done,
    .read_value, .found_position, .list_length, .status, .req, .rd_data
  );

  ple_store u_store (
    .clk, .req, .rd_data
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list engine testbench
// Drives directed and random list requests through the command port and
// checks every result against a fixed expected row or a ring-buffer model kept here.
// ----------------------------------------------------------------------------
module tb;
  import ple_pkg::*;

  localparam int IdlePct   = 24;
  localparam int PhaseLen  = 250;
  localparam int NumPhases = 7;
  localparam int DogLimit  = 4000;

  typedef struct {
    logic [31:0] rd;
    logic [7:0]  fpos;
    logic [8:0]  len;
    logic [2:0]  st;
  } list_result_t;

  typedef struct {
    logic [3:0]  act;
    logic [7:0]  pos;
    logic [31:0] val;
    bit          typed;
    list_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] action = '0;
  logic [7:0] position = '0;
  logic signed [31:0] value = '0;
  logic busy, done;
  logic signed [31:0] read_value;
  logic [7:0] found_position;
  logic [8:0] list_length;
  logic [2:0] status;

  positional_list_engine DUT (
    .clk(clk), .rst(rst), .start(start), .action(action), .position(position),
    .value(value), .busy(busy), .done(done), .read_value(read_value),
    .found_position(found_position), .list_length(list_length), .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model of the list: position p lives in slot head + p.
  logic [31:0] ring [Capacity];
  logic [7:0]  head_slot = '0;
  int          live = 0;

  list_result_t pending_results[$];
  int mismatches = 0;
  int idle_dog = 0;
  bit idling_on = 1'b1;

  function automatic list_result_t apply_request(logic [3:0] act, logic [7:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int i;
    r = '{rd: '0, fpos: '0, len: '0, st: ST_OK};
    case (act)
      ACT_PUSH_HEAD, ACT_PUSH_TAIL: begin
        if (live >= Capacity) r.st = ST_FULL;
        else begin
          if (act == ACT_PUSH_HEAD) begin
            head_slot = head_slot - 8'd1;
            ring[head_slot] = val;
          end else begin
            ring[8'(head_slot + live)] = val;
          end
          live++;
        end
      end
      ACT_POP_HEAD, ACT_POP_TAIL: begin
        if (live == 0) r.st = ST_EMPTY;
        else begin
          if (act == ACT_POP_HEAD) begin
            r.rd = ring[head_slot];
            head_slot = head_slot + 8'd1;
          end else begin
            r.rd = ring[8'(head_slot + live - 1)];
          end
          live--;
        end
      end
      ACT_READ, ACT_UPDATE, ACT_DELETE, ACT_INSERT: begin
        if (live == 0) r.st = ST_EMPTY;
        else if (pos >= live) r.st = ST_RANGE;
        else if (act == ACT_READ) r.rd = ring[8'(head_slot + pos)];
        else if (act == ACT_UPDATE) ring[8'(head_slot + pos)] = val;
        else if (act == ACT_DELETE) begin
          if (pos == 0) head_slot = head_slot + 8'd1;
          else
            for (i = pos; i + 1 < live; i++)
              ring[8'(head_slot + i)] = ring[8'(head_slot + i + 1)];
          live--;
        end else if (live >= Capacity) r.st = ST_FULL;
        else begin
          for (i = live; i > pos + 1; i--)
            ring[8'(head_slot + i)] = ring[8'(head_slot + i - 1)];
          ring[8'(head_slot + pos + 1)] = val;
          live++;
        end
      end
      ACT_FIND: begin
        if (live == 0) r.st = ST_EMPTY;
        else begin
          r.st = ST_NOTFOUND;
          for (i = 0; i < live; i++)
            if (ring[8'(head_slot + i)] == val) begin
              r.fpos = 8'(i);
              r.st = ST_OK;
              break;
            end
        end
      end
      default: ;
    endcase
    r.len = 9'(live);
    return r;
  endfunction

  // One request: optional idle cycles, then hold start until the transfer.
  task automatic send_request(logic [3:0] act, logic [7:0] pos, logic [31:0] val,
                              bit typed, list_result_t typed_res);
    list_result_t r;
    while (idling_on && $urandom_range(99) < IdlePct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    action <= act;
    position <= pos;
    value <= val;
    do @(posedge clk); while (busy);
    r = apply_request(act, pos, val);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    list_result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        e = pending_results.pop_front();
        if (read_value !== e.rd || found_position !== e.fpos ||
            list_length !== e.len || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch at %0t: exp rd=%h fpos=%0d len=%0d st=%0d,",
                      " got rd=%h fpos=%0d len=%0d st=%0d"},
                     $realtime, e.rd, e.fpos, e.len, e.st,
                     read_value, found_position, list_length, status);
        end
      end
    end
  end

  // A cycle with neither a transfer nor a result counts toward the timeout.
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_dog <= 0;
    else idle_dog <= idle_dog + 1;
    if (idle_dog >= DogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic list_result_t res_of(logic [31:0] rd, logic [7:0] fp, int len,
                                          status_t st);
    list_result_t r;
    r = '{rd: rd, fpos: fp, len: 9'(len), st: st};
    return r;
  endfunction

  function automatic logic [3:0] pick_action(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin
        if (r < 70) return r[0] ? ACT_PUSH_TAIL : ACT_PUSH_HEAD;
        if (r < 80) return ACT_INSERT;
        if (r < 90) return ACT_READ;
        return ACT_FIND;
      end
      2: begin
        if (r < 25) return ACT_POP_HEAD;
        if (r < 45) return ACT_POP_TAIL;
        if (r < 65) return ACT_DELETE;
        if (r < 75) return ACT_UPDATE;
        if (r < 88) return ACT_FIND;
        return ACT_READ;
      end
      default: begin
        if (r < 8) return 4'($urandom_range(10, 15));
        return 4'($urandom_range(0, 9));
      end
    endcase
  endfunction

  stim_row_t directed[$];
  list_result_t none;

  initial begin
    int k;
    int mode;
    logic [3:0] a;
    logic [7:0] p;
    logic [31:0] v;
    int r;

    none = res_of('0, '0, 0, ST_OK);
    directed = '{
      '{ACT_LENGTH,    8'd0,   32'd0,        1, res_of('0, '0, 0, ST_OK)},
      '{ACT_POP_HEAD,  8'd0,   32'd0,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_POP_TAIL,  8'd0,   32'd0,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_READ,      8'd0,   32'd0,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_UPDATE,    8'd255, 32'd1,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_DELETE,    8'd0,   32'd0,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_INSERT,    8'd0,   32'd5,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_FIND,      8'd0,   32'd0,        1, res_of('0, '0, 0, ST_EMPTY)},
      '{ACT_PUSH_HEAD, 8'd0,   32'h7fffffff, 1, res_of('0, '0, 1, ST_OK)},
      '{ACT_PUSH_TAIL, 8'd0,   32'h80000000, 1, res_of('0, '0, 2, ST_OK)},
      '{ACT_READ,      8'd255, 32'd0,        1, res_of('0, '0, 2, ST_RANGE)},
      '{ACT_INSERT,    8'd2,   32'd0,        1, res_of('0, '0, 2, ST_RANGE)},
      '{ACT_READ,      8'd0,   32'd0,        1, res_of(32'h7fffffff, '0, 2, ST_OK)},
      '{ACT_READ,      8'd1,   32'd0,        1, res_of(32'h80000000, '0, 2, ST_OK)},
      '{ACT_FIND,      8'd0,   32'h80000000, 1, res_of('0, 8'd1, 2, ST_OK)},
      '{ACT_FIND,      8'd0,   32'd5,        1, res_of('0, '0, 2, ST_NOTFOUND)},
      '{ACT_UPDATE,    8'd1,   32'hffffffff, 0, none},
      '{ACT_INSERT,    8'd0,   32'd0,        0, none},
      '{ACT_PUSH_HEAD, 8'd0,   32'h12345678, 0, none},
      '{ACT_DELETE,    8'd2,   32'd0,        0, none},
      '{ACT_DELETE,    8'd0,   32'd0,        0, none},
      '{ACT_POP_TAIL,  8'd0,   32'd0,        0, none},
      '{4'd15,         8'd0,   32'd0,        0, none},
      '{ACT_POP_HEAD,  8'd0,   32'd0,        0, none},
      '{ACT_LENGTH,    8'd0,   32'd0,        0, none}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i])
      send_request(directed[i].act, directed[i].pos, directed[i].val,
                   directed[i].typed, directed[i].res);

    for (k = 0; k < NumPhases * PhaseLen; k++) begin
      // Phases lean on filling, mixing and draining so the list hits full.
      if (k % PhaseLen == 0) begin
        start <= 1'b0;
        wait (pending_results.size() == 0);
        @(negedge clk);
      end
      mode = (k / PhaseLen == 5) ? 2 :
             (k / PhaseLen == 1 || k / PhaseLen == 4) ? 1 : 0;
      idling_on = !(k >= 2 * PhaseLen && k < 3 * PhaseLen);
      a = pick_action(mode);
      r = $urandom_range(99);
      if (live > 0 && r < 70) p = 8'($urandom_range(live - 1));
      else if (r < 85) p = 8'($urandom_range(255, live > 255 ? 255 : live));
      else p = 8'($urandom);
      if (live > 0 && $urandom_range(99) < 40)
        v = ring[8'(head_slot + $urandom_range(live - 1))];
      else v = $urandom;
      send_request(a, p, v, 0, none);
    end

    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ple_pkg.sv
design/ple_store.sv
design/ple_ctrl.sv
design/positional_list_engine.sv
verif/tb.sv
